>>> design/gpcm_pkg.sv
// Shared types, constants, square-root step and palette table of the color map.
package gpcm_pkg;

   // Gamma register layout: low bits are root terms, high bits are square terms
   localparam int GAMMA_W     = 16;
   localparam int ROOT_BITS   = 12;
   localparam int SQUARE_BITS = GAMMA_W - ROOT_BITS;
   localparam logic [GAMMA_W-1:0] GAMMA_RESET = 16'd4096;

   // Sample format Q2.16 and its decoded limits
   localparam int SAMPLE_W = 18;
   localparam logic [SAMPLE_W-1:0] SAMPLE_ONE = 18'd65536;

   // Square root: 32 result bits, two digit steps per register stage
   localparam int SQ_ROOT_W = 32;
   localparam int SQ_REM_W  = 35;
   localparam int SQ_STEPS  = 2;
   localparam int SQ_STAGES = SQ_ROOT_W / SQ_STEPS;

   localparam int COLOR_W = 24;
   localparam int PAL_IDX_W = 6;

   typedef struct packed {
      logic [SQ_REM_W-1:0]  rem;
      logic [SQ_ROOT_W-1:0] root;
      logic [SQ_ROOT_W-1:0] tsh;
   } sq_state_type;

   // Payload that travels with each beat through the power stages
   typedef struct packed {
      logic        black;
      logic        exact;
      logic        acc_one;
      logic [31:0] acc;
      logic [15:0] s;
   } item_type;

   // One restoring digit step of floor(sqrt(t << 32))
   function automatic sq_state_type sq_step(sq_state_type st);
      logic [SQ_REM_W-1:0] rem2;
      logic [SQ_REM_W-1:0] trial;
      sq_state_type        nx;
      rem2  = {st.rem[SQ_REM_W-3:0], st.tsh[SQ_ROOT_W-1 -: 2]};
      trial = {1'b0, st.root, 2'b01};
      if (rem2 >= trial) begin
         nx.rem  = rem2 - trial;
         nx.root = {st.root[SQ_ROOT_W-2:0], 1'b1};
      end else begin
         nx.rem  = rem2;
         nx.root = {st.root[SQ_ROOT_W-2:0], 1'b0};
      end
      nx.tsh = {st.tsh[SQ_ROOT_W-3:0], 2'b00};
      return nx;
   endfunction

   // Palette colors, red in the low byte; entries past the eighth are black
   function automatic logic [COLOR_W-1:0] pal_color(logic [PAL_IDX_W-1:0] idx);
      logic [COLOR_W-1:0] c;
      case (idx)
         6'd0:    c = {8'd88,  8'd73,  8'd58};
         6'd1:    c = {8'd39,  8'd97,  8'd86};
         6'd2:    c = {8'd152, 8'd228, 8'd249};
         6'd3:    c = {8'd16,  8'd16,  8'd16};
         6'd4:    c = {8'd158, 8'd201, 8'd212};
         6'd5:    c = {8'd140, 8'd137, 8'd134};
         6'd6:    c = {8'd83,  8'd92,  8'd104};
         6'd7:    c = {8'd128, 8'd45,  8'd82};
         default: c = '0;
      endcase
      return c;
   endfunction

endpackage

>>> design/gamma_palette_color_map_top.sv
// Top level of the gamma palette color map: power pipeline, blend and output skid.
//
//   channel  direction  handshake             payload
//   req      in         req_tvalid/tready     req_tdata[17:0] sample_value
//   rsp      out        rsp_tvalid/tready     rsp_tdata red, green, blue
//   csr      in         csr_valid/ready       csr_wdata[15:0] gamma_exponent
//
// One beat per cycle while the skid is empty. The pipeline is an input register,
// twelve 17-stage square-root blocks, four square stages and three blend stages.
// Synchronous reset clears all valid bits and loads gamma 1.0.
// A stalled result moves into a skid register; the pipeline freezes only when the
// skid is full, so no beat is lost or repeated.
// A gamma write is taken only with no beat in flight and no sample offered.
module gamma_palette_color_map_top #(
   parameter int PALETTE_ENTRIES = 8,
   parameter int FRACTION_BITS   = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [17:0] sample_value, [23:18] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] red_out, [15:8] green_out, [23:16] blue_out
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_wdata    // [15:0] gamma_exponent
);
   import gpcm_pkg::*;

   logic               en;
   logic [GAMMA_W-1:0] gamma_ff;

   // Count beats in flight; at most 214 (pipeline, output and skid registers)
   logic [7:0] inflight_ff, inflight_in;

   always_comb begin
      inflight_in = inflight_ff;
      if ((req_tvalid && req_tready) && !(rsp_tvalid && rsp_tready)) begin
         inflight_in = inflight_ff + 8'd1;
      end else if (!(req_tvalid && req_tready) && (rsp_tvalid && rsp_tready)) begin
         inflight_in = inflight_ff - 8'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   // Gamma register, written only while idle
   assign csr_ready = (inflight_ff == 8'd0) && !req_tvalid;
   always_ff @(posedge clock) begin
      if (reset) begin
         gamma_ff <= GAMMA_RESET;
      end else if (csr_valid && csr_ready) begin
         gamma_ff <= csr_wdata;
      end
   end

   // Input stage: decode range and exact one
   logic                v0_ff;
   item_type            item0_ff, item0_in;
   logic [SAMPLE_W-1:0] raw;

   assign raw = req_tdata[SAMPLE_W-1:0];
   always_comb begin
      item0_in.black   = raw > SAMPLE_ONE;
      item0_in.exact   = raw == SAMPLE_ONE;
      item0_in.acc_one = 1'b1;
      item0_in.acc     = '0;
      item0_in.s       = raw[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item0_ff <= item0_in;
      end
   end

   // Root terms, gamma bit 11 down to bit 0
   logic        rv   [ROOT_BITS+1];
   logic [31:0] rt   [ROOT_BITS+1];
   item_type    ritem[ROOT_BITS+1];

   assign rv[0]    = v0_ff;
   assign rt[0]    = {item0_ff.s, 16'd0};
   assign ritem[0] = item0_ff;

   for (genvar k = 0; k < ROOT_BITS; k++) begin : g_root
      gpcm_root_block u_root (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .gbit      (gamma_ff[ROOT_BITS-1-k]),
         .in_valid  (rv[k]),
         .in_t      (rt[k]),
         .in_item   (ritem[k]),
         .out_valid (rv[k+1]),
         .out_t     (rt[k+1]),
         .out_item  (ritem[k+1])
      );
   end

   // Square terms, gamma bit 12 up to bit 15, restarting from the sample
   logic        qv   [SQUARE_BITS+1];
   logic [31:0] qt   [SQUARE_BITS+1];
   item_type    qitem[SQUARE_BITS+1];

   assign qv[0]    = rv[ROOT_BITS];
   assign qt[0]    = {ritem[ROOT_BITS].s, 16'd0};
   assign qitem[0] = ritem[ROOT_BITS];

   for (genvar k = 0; k < SQUARE_BITS; k++) begin : g_square
      gpcm_square_stage u_square (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .gbit      (gamma_ff[ROOT_BITS+k]),
         .in_valid  (qv[k]),
         .in_t      (qt[k]),
         .in_item   (qitem[k]),
         .out_valid (qv[k+1]),
         .out_t     (qt[k+1]),
         .out_item  (qitem[k+1])
      );
   end

   // Palette blend
   logic               pv;
   logic [COLOR_W-1:0] pd;

   gpcm_blend #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES),
      .FRACTION_BITS   (FRACTION_BITS)
   ) u_blend (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (qv[SQUARE_BITS]),
      .in_item   (qitem[SQUARE_BITS]),
      .out_valid (pv),
      .out_color (pd)
   );

   // Output register with skid
   logic               out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;
   logic [COLOR_W-1:0] out_data_ff, out_data_in, skid_data_ff, skid_data_in;

   assign en = !skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (rsp_tready) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!out_valid_ff || rsp_tready) begin
         out_valid_in = pv;
         out_data_in  = pd;
      end else if (pv) begin
         skid_valid_in = 1'b1;
         skid_data_in  = pd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign req_tready = en;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

>>> design/gpcm_sqrt_stage.sv
// One register stage of the pipelined square root, two digit steps deep.
module gpcm_sqrt_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  gpcm_pkg::sq_state_type in_sq,
   input  gpcm_pkg::item_type    in_item,
   output logic                  out_valid,
   output gpcm_pkg::sq_state_type out_sq,
   output gpcm_pkg::item_type    out_item
);
   import gpcm_pkg::*;

   logic         valid_ff;
   sq_state_type sq_ff, sq_in;
   item_type     item_ff;

   // Run the digit steps of this stage
   always_comb begin
      sq_in = in_sq;
      for (int i = 0; i < SQ_STEPS; i++) begin
         sq_in = sq_step(sq_in);
      end
   end

   // Advance valid with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff   <= sq_in;
         item_ff <= in_item;
      end
   end

   assign out_valid = valid_ff;
   assign out_sq    = sq_ff;
   assign out_item  = item_ff;

endmodule

>>> design/gpcm_root_block.sv
// One root term: full square root of t, then an optional accumulator multiply.
module gpcm_root_block (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               gbit,
   input  logic               in_valid,
   input  logic [31:0]        in_t,
   input  gpcm_pkg::item_type in_item,
   output logic               out_valid,
   output logic [31:0]        out_t,
   output gpcm_pkg::item_type out_item
);
   import gpcm_pkg::*;

   logic         valid_w [SQ_STAGES+1];
   sq_state_type sq_w    [SQ_STAGES+1];
   item_type     item_w  [SQ_STAGES+1];

   logic         valid_ff;
   logic [31:0]  t_ff;
   item_type     item_ff, item_in;
   logic [63:0]  prod;

   assign valid_w[0] = in_valid;
   assign sq_w[0]    = '{rem: '0, root: '0, tsh: in_t};
   assign item_w[0]  = in_item;

   // Square-root stages
   for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sq
      gpcm_sqrt_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (valid_w[k]),
         .in_sq     (sq_w[k]),
         .in_item   (item_w[k]),
         .out_valid (valid_w[k+1]),
         .out_sq    (sq_w[k+1]),
         .out_item  (item_w[k+1])
      );
   end

   // Take the root into the accumulator when this gamma bit is set
   always_comb begin
      prod    = item_w[SQ_STAGES].acc * sq_w[SQ_STAGES].root;
      item_in = item_w[SQ_STAGES];
      if (gbit) begin
         item_in.acc_one = 1'b0;
         if (item_w[SQ_STAGES].acc_one) begin
            item_in.acc = sq_w[SQ_STAGES].root;
         end else begin
            item_in.acc = prod[63:32];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_w[SQ_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t_ff    <= sq_w[SQ_STAGES].root;
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_t     = t_ff;
   assign out_item  = item_ff;

endmodule

>>> design/gpcm_square_stage.sv
// One square term: optional accumulator multiply and squaring of t.
module gpcm_square_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               gbit,
   input  logic               in_valid,
   input  logic [31:0]        in_t,
   input  gpcm_pkg::item_type in_item,
   output logic               out_valid,
   output logic [31:0]        out_t,
   output gpcm_pkg::item_type out_item
);
   import gpcm_pkg::*;

   logic        valid_ff;
   logic [31:0] t_ff;
   item_type    item_ff, item_in;
   logic [63:0] acc_prod;
   logic [63:0] sq_prod;

   // Multiply accumulator and square t side by side
   always_comb begin
      acc_prod = in_item.acc * in_t;
      sq_prod  = in_t * in_t;
      item_in  = in_item;
      if (gbit) begin
         item_in.acc_one = 1'b0;
         if (in_item.acc_one) begin
            item_in.acc = in_t;
         end else begin
            item_in.acc = acc_prod[63:32];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t_ff    <= sq_prod[63:32];
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_t     = t_ff;
   assign out_item  = item_ff;

endmodule

>>> design/gpcm_blend.sv
// Palette position, color lookup and linear blend in three register stages.
module gpcm_blend #(
   parameter int PALETTE_ENTRIES = 8,
   parameter int FRACTION_BITS   = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           in_valid,
   input  gpcm_pkg::item_type             in_item,
   output logic                           out_valid,
   output logic [gpcm_pkg::COLOR_W-1:0]   out_color
);
   import gpcm_pkg::*;

   localparam int IDX_W = $clog2(PALETTE_ENTRIES);
   localparam int INT_W = IDX_W + 1;
   localparam int P_W   = FRACTION_BITS + 1;
   localparam int POS_W = P_W + IDX_W;
   localparam int V_W   = FRACTION_BITS + 9;
   localparam int LAST  = PALETTE_ENTRIES - 1;

   // Stage one: power cut to the fraction width, scaled to a position
   logic             v1_ff, black1_ff;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [P_W-1:0]   p;

   always_comb begin
      if (in_item.exact || in_item.acc_one) begin
         p = P_W'(1) << FRACTION_BITS;
      end else begin
         p = {1'b0, in_item.acc[31 -: FRACTION_BITS]};
      end
      pos_in = POS_W'(p) * POS_W'(LAST);
   end

   // Stage two: split position, clamp indexes, read palette
   logic                 v2_ff, black2_ff;
   logic [COLOR_W-1:0]   lo_c_ff, hi_c_ff, lo_c_in, hi_c_in;
   logic [FRACTION_BITS-1:0] w_ff;
   logic [INT_W-1:0]     ip, lo, hi;

   always_comb begin
      ip = pos_ff[POS_W-1 -: INT_W];
      lo = (ip > INT_W'(LAST)) ? INT_W'(LAST) : ip;
      hi = lo + INT_W'(1);
      if (hi > INT_W'(LAST)) begin
         hi = INT_W'(LAST);
      end
      lo_c_in = pal_color(PAL_IDX_W'(lo));
      hi_c_in = pal_color(PAL_IDX_W'(hi));
   end

   // Stage three: weighted sum per channel, truncated
   logic               v3_ff;
   logic [COLOR_W-1:0] color_ff, color_in;
   logic [P_W-1:0]     omw;
   logic [V_W-1:0]     v;

   always_comb begin
      omw      = (P_W'(1) << FRACTION_BITS) - P_W'(w_ff);
      color_in = '0;
      v        = '0;
      for (int c = 0; c < 3; c++) begin
         v = V_W'(lo_c_ff[c*8 +: 8]) * V_W'(omw) + V_W'(hi_c_ff[c*8 +: 8]) * V_W'(w_ff);
         color_in[c*8 +: 8] = v[FRACTION_BITS +: 8];
      end
      if (black2_ff) begin
         color_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pos_ff    <= pos_in;
         black1_ff <= in_item.black;
         lo_c_ff   <= lo_c_in;
         hi_c_ff   <= hi_c_in;
         w_ff      <= pos_ff[FRACTION_BITS-1:0];
         black2_ff <= black1_ff;
         color_ff  <= color_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_color = color_ff;

endmodule

>>> design/gpcm_checker.sv
// Port-level checks of the color map top level, bound to it.
module gpcm_port_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        csr_valid,
   input logic        csr_ready
);

   // Hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result beat changed");

   // Drop input ready only behind a waiting result
   a_ready_skid: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with no result waiting");

   // Come out of reset empty and ready
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("not empty after reset");

   // Take a register write only while nothing is offered or waiting
   a_csr_quiet: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |-> !rsp_tvalid && !req_tvalid)
      else $error("register write taken while busy");

endmodule

bind gamma_palette_color_map_top gpcm_port_checker u_checker (.*);

>>> dv/gpcm_checker.sv
// Scoreboard for the gamma palette color map: tracks gamma, predicts colors, compares beats.
`timescale 1ns / 100ps

module gpcm_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [15:0] csr_wdata,
   output int          fail_count,
   output int          pending_count
);
   import gpcm_pkg::*;

   // Palette as seen by the scoreboard
   localparam logic [7:0] PAL_R [8] = '{8'd58, 8'd86, 8'd249, 8'd16, 8'd212, 8'd134, 8'd104, 8'd82};
   localparam logic [7:0] PAL_G [8] = '{8'd73, 8'd97, 8'd228, 8'd16, 8'd201, 8'd137, 8'd92, 8'd45};
   localparam logic [7:0] PAL_B [8] = '{8'd88, 8'd39, 8'd152, 8'd16, 8'd158, 8'd140, 8'd83, 8'd128};

   logic [GAMMA_W-1:0] gamma_q;
   logic [23:0]        color_q[$];

   // Integer square root, bit by bit
   function automatic bit [63:0] int_sqrt(bit [63:0] n);
      bit [63:0] res;
      bit [63:0] b;
      res = 0;
      b   = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (n >= res + b) begin
            n   = n - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // Sample raised to gamma, Q.32 result
   function automatic bit [63:0] gamma_power(bit [15:0] s, bit [15:0] g);
      bit [63:0] x;
      bit [63:0] acc;
      bit [63:0] t;
      x   = 64'(s) << 16;
      acc = 64'd1 << 32;
      t   = x;
      for (int j = 11; j >= 0; j--) begin
         t = int_sqrt(t << 32);
         if (g[j]) acc = (acc * t) >> 32;
      end
      t = x;
      for (int j = 12; j < 16; j++) begin
         if (g[j]) acc = (acc * t) >> 32;
         t = (t * t) >> 32;
      end
      return acc;
   endfunction

   // Expected {blue, green, red} for one sample
   function automatic logic [23:0] map_color(logic [17:0] raw, logic [15:0] g);
      bit [63:0] p;
      bit [63:0] pos;
      bit [63:0] w;
      bit [63:0] lo;
      bit [63:0] hi;
      bit [63:0] r;
      bit [63:0] gr;
      bit [63:0] bl;
      if (raw > SAMPLE_ONE) return '0;
      if (raw == SAMPLE_ONE) p = 64'd1 << 32;
      else p = gamma_power(raw[15:0], g);
      p   = p >> 16;
      pos = p * 7;
      lo  = pos >> 16;
      w   = pos & 64'hFFFF;
      if (lo > 7) lo = 7;
      hi = lo + 1;
      if (hi > 7) hi = 7;
      r  = (PAL_R[lo[2:0]] * (65536 - w) + PAL_R[hi[2:0]] * w) >> 16;
      gr = (PAL_G[lo[2:0]] * (65536 - w) + PAL_G[hi[2:0]] * w) >> 16;
      bl = (PAL_B[lo[2:0]] * (65536 - w) + PAL_B[hi[2:0]] * w) >> 16;
      return {bl[7:0], gr[7:0], r[7:0]};
   endfunction

   assign pending_count = color_q.size();

   // Track gamma, queue predictions, compare results
   always @(posedge clock) begin
      logic [23:0] exp_c;
      if (reset) begin
         gamma_q    <= GAMMA_RESET;
         fail_count <= 0;
         color_q.delete();
      end else begin
         if (csr_valid && csr_ready) gamma_q <= csr_wdata;
         if (req_tvalid && req_tready) color_q = {color_q, map_color(req_tdata[17:0], gamma_q)};
         if (rsp_tvalid && rsp_tready) begin
            if (color_q.size() == 0) begin
               $display("%0t: unexpected result beat %h", $time, rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               exp_c = color_q.pop_front();
               if (exp_c[7:0] !== rsp_tdata[7:0])
                  $display("%0t: red expected %0d actual %0d", $time, exp_c[7:0], rsp_tdata[7:0]);
               if (exp_c[15:8] !== rsp_tdata[15:8])
                  $display("%0t: green expected %0d actual %0d", $time, exp_c[15:8],
                           rsp_tdata[15:8]);
               if (exp_c[23:16] !== rsp_tdata[23:16])
                  $display("%0t: blue expected %0d actual %0d", $time, exp_c[23:16],
                           rsp_tdata[23:16]);
               if (exp_c !== rsp_tdata) fail_count <= fail_count + 1;
            end
         end
      end
   end

endmodule

>>> dv/gamma_palette_color_map_top_tb.sv
// Testbench top for the gamma palette color map: stimulus, back-pressure and verdict.
`timescale 1ns / 100ps

module gamma_palette_color_map_top_tb;
   import gpcm_pkg::*;

   localparam int PHASES      = 9;
   localparam int PHASE_ITEMS = 140;
   localparam int HOLD_CYCLES = 600;
   localparam int IDLE_LIMIT  = 5000;
   localparam int DRAIN_WAIT  = 250;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [23:0] rsp_tdata;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [15:0] csr_wdata = '0;
   int          fail_count;
   int          pending_count;
   bit          hold_request = 0;
   bit          no_gaps = 0;
   int          idle_cycles = 0;
   int          sent = 0;

   always #6 clock = ~clock;

   gamma_palette_color_map_top u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata)
   );

   gpcm_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   // Offer one sample beat after a random gap
   task automatic send_sample(logic [17:0] s);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, s};
      do @(posedge clock); while (!req_tready);
      sent++;
   endtask

   // Hold until every expected color has arrived
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      @(posedge clock);
   endtask

   // Write one gamma value while idle
   task automatic write_gamma(logic [15:0] g);
      csr_valid <= 1'b1;
      csr_wdata <= g;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Random sample: mostly in range, some edges, some over the full field
   function automatic logic [17:0] pick_sample();
      int k;
      k = $urandom_range(0, 99);
      if (k < 60) return 18'($urandom_range(0, 65536));
      if (k < 70) begin
         case ($urandom_range(0, 3))
            0: return 18'd0;
            1: return 18'd65536;
            2: return 18'd65535;
            default: return 18'd1;
         endcase
      end
      return 18'($urandom);
   endfunction

   // Receiver: random stalls, one long hold-off on request
   initial begin
      int n;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            n = HOLD_CYCLES;
            hold_request = 0;
         end else begin
            n = no_gaps ? 0 : $urandom_range(0, 9);
         end
         if (n != 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Watchdog on cycles without any beat
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (!reset && idle_cycles >= IDLE_LIMIT) begin
         $display("timeout after %0d idle cycles", idle_cycles);
         $display("gamma_palette_color_map_top_tb NOT OK");
         $finish;
      end
   end

   // Stimulus
   initial begin
      logic [15:0] gammas [PHASES];
      logic [17:0] directed [14];
      gammas   = '{16'd4096, 16'd1, 16'd65535, 16'd2048, 16'd12288, 16'd6144,
                   16'd0, 16'd0, 16'd0};
      directed = '{18'd0, 18'd65536, 18'd65535, 18'd1, 18'd65537, 18'h3FFFF, 18'h20000,
                   18'h1FFFF, 18'd32768, 18'd9362, 18'd18725, 18'd56173, 18'd46811,
                   18'd2};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph >= 6) gammas[ph] = 16'($urandom_range(1, 65535));
         write_gamma(gammas[ph]);
         no_gaps = (ph % 3 == 2);
         // Fill the pipeline against a stalled receiver
         if (ph == 2) hold_request = 1;
         if (ph < 6) foreach (directed[i]) send_sample(directed[i]);
         for (int i = 0; i < (ph == 2 ? 2 * PHASE_ITEMS : PHASE_ITEMS); i++)
            send_sample(pick_sample());
         drain_results();
      end
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("sent %0d samples over %0d gamma settings incl. 1, 65535 and 1.0,", sent, PHASES);
      $display("with random stalls, a long output hold-off and full-range samples");
      if (fail_count == 0 && pending_count == 0)
         $display("gamma_palette_color_map_top_tb OK");
      else
         $display("gamma_palette_color_map_top_tb NOT OK");
      $finish;
   end

endmodule

>>> sim.f
design/gpcm_pkg.sv
design/gpcm_sqrt_stage.sv
design/gpcm_root_block.sv
design/gpcm_square_stage.sv
design/gpcm_blend.sv
design/gamma_palette_color_map_top.sv
design/gpcm_checker.sv
dv/gpcm_checker.sv
dv/gamma_palette_color_map_top_tb.sv
